// ===== sv/rvfc_pkg.sv =====
// ----------------------------------------------------------------------------
// rvfc_pkg: shared constants and types for the range value frequency counter
// Sizes of the element store and of the per-block tables, and the
// command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package rvfc_pkg;

    localparam int DEPTH = 256;
    localparam int BLOCK = 16;
    localparam int AW    = 8;
    localparam int SW    = 4;
    localparam int NBLK  = DEPTH / BLOCK;
    localparam int CW    = 5;
    localparam int MW    = 9;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef struct packed {
        logic          load;
        logic          clr;
        logic          elem_rd;
        logic [AW-1:0] elem_addr;
        logic          elem_wr;
        logic          tab_rd;
        logic [AW-1:0] tab_addr;
        logic          tab_wr;
        logic          acc_elem;
        logic          acc_tab;
        logic          scan_rm;
        logic          scan_add;
        logic          scan_clr;
        logic          commit_rm;
    } rvfc_cmd_t;

    typedef struct packed {
        logic          is_query;
        logic [AW-1:0] left;
        logic [AW-1:0] right;
    } rvfc_sts_t;

endpackage

// ===== sv/rvfc_datapath.sv =====
// ----------------------------------------------------------------------------
// rvfc_datapath: element store, block tables and match accumulator
// Memories with registered reads; slot searches run one slot per cycle.
// ----------------------------------------------------------------------------
module rvfc_datapath
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    kind,
    input  logic [rvfc_pkg::AW-1:0] left_index,
    input  logic [rvfc_pkg::AW-1:0] right_index,
    input  logic [31:0]             item_value,
    input  rvfc_pkg::rvfc_cmd_t     cmd,
    output rvfc_pkg::rvfc_sts_t     sts,
    output logic [rvfc_pkg::MW-1:0] match_count
);

    logic [31:0]             elem_mem [rvfc_pkg::DEPTH];
    logic [31:0]             tval_mem [rvfc_pkg::DEPTH];
    logic [rvfc_pkg::CW-1:0] tcnt_mem [rvfc_pkg::DEPTH];

    logic                    kind_reg;
    logic [rvfc_pkg::AW-1:0] left_reg, right_reg;
    logic [31:0]             val_reg, old_reg, eq_val;
    logic [31:0]             erd_reg, trd_v_reg;
    logic [rvfc_pkg::CW-1:0] trd_c_reg;
    logic [rvfc_pkg::AW-1:0] trd_a_reg;
    logic [rvfc_pkg::MW-1:0] acc_reg;
    logic                    hit_reg, free_reg;
    logic [rvfc_pkg::AW-1:0] hit_a_reg, free_a_reg;
    logic [rvfc_pkg::CW-1:0] hit_c_reg;
    logic [rvfc_pkg::CW-1:0] tcnt_eff;
    logic [31:0]             tval_eff;
    logic [rvfc_pkg::AW-1:0] wa;
    logic [31:0]             wv;
    logic [rvfc_pkg::CW-1:0] wc;
    logic [rvfc_pkg::AW-1:0] ea;
    logic [31:0]             ed;

    assign sts.is_query = kind_reg;
    assign sts.left     = left_reg;
    assign sts.right    = right_reg;
    assign match_count  = acc_reg;

    assign tcnt_eff = trd_c_reg;
    assign tval_eff = trd_v_reg;
    assign eq_val   = cmd.scan_add ? val_reg : old_reg;
    assign ea       = cmd.clr ? cmd.elem_addr : left_reg;
    assign ed       = cmd.clr ? 32'd0 : val_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg  <= kind;
            left_reg  <= left_index;
            right_reg <= right_index;
            val_reg   <= item_value;
        end
        if (cmd.elem_rd)
            erd_reg <= elem_mem[cmd.elem_addr];
        if (cmd.elem_wr)
            elem_mem[ea] <= ed;
        if (cmd.tab_rd)
        begin
            trd_v_reg <= tval_mem[cmd.tab_addr];
            trd_c_reg <= tcnt_mem[cmd.tab_addr];
            trd_a_reg <= cmd.tab_addr;
        end
        if (cmd.tab_wr)
        begin
            tval_mem[wa] <= wv;
            tcnt_mem[wa] <= wc;
        end
    end

    // old element value is captured right after its read
    always_ff @(posedge clk)
    begin
        if (cmd.scan_clr)
            old_reg <= erd_reg;
    end

    always_comb
    begin
        wa = hit_a_reg;
        wv = val_reg;
        wc = hit_c_reg + rvfc_pkg::CW'(1);
        if (cmd.clr)
        begin
            // first slot of each block holds the whole block at value 0
            wa = cmd.tab_addr;
            wv = 32'd0;
            wc = (cmd.tab_addr[rvfc_pkg::SW-1:0] == '0)
               ? rvfc_pkg::CW'(rvfc_pkg::BLOCK) : '0;
        end
        else if (cmd.commit_rm)
        begin
            wv = old_reg;
            wc = hit_c_reg - rvfc_pkg::CW'(1);
        end
        else if (!hit_reg)
        begin
            wa = free_a_reg;
            wc = rvfc_pkg::CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            hit_reg       <= 1'b0;
            free_reg      <= 1'b0;
            hit_a_reg     <= '0;
            free_a_reg    <= '0;
            hit_c_reg     <= '0;
        end
        else
        begin
            if (cmd.load)
                acc_reg <= '0;
            if (cmd.acc_elem && erd_reg == val_reg)
                acc_reg <= acc_reg + rvfc_pkg::MW'(1);
            if (cmd.acc_tab && tcnt_eff != '0 && tval_eff == val_reg)
                acc_reg <= acc_reg + rvfc_pkg::MW'(tcnt_eff);
            if (cmd.scan_clr)
            begin
                hit_reg  <= 1'b0;
                free_reg <= 1'b0;
            end
            else if (cmd.scan_rm || cmd.scan_add)
            begin
                // first matching slot and first free slot win
                if (!hit_reg && tcnt_eff != '0 && tval_eff == eq_val)
                begin
                    hit_reg   <= 1'b1;
                    hit_a_reg <= trd_a_reg;
                    hit_c_reg <= tcnt_eff;
                end
                if (!free_reg && tcnt_eff == '0)
                begin
                    free_reg   <= 1'b1;
                    free_a_reg <= trd_a_reg;
                end
            end
        end
    end

endmodule

// ===== sv/rvfc_controller.sv =====
// ----------------------------------------------------------------------------
// rvfc_controller: sequencer for write and query items
// Walks element indexes and table slots, issuing datapath commands.
// ----------------------------------------------------------------------------
module rvfc_controller
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    output logic                done,
    input  rvfc_pkg::rvfc_sts_t sts,
    output rvfc_pkg::rvfc_cmd_t cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DEC    = 4'd1;
    localparam logic [3:0] S_OLD    = 4'd2;
    localparam logic [3:0] S_OLDCAP = 4'd3;
    localparam logic [3:0] S_RMSCAN = 4'd4;
    localparam logic [3:0] S_RMCOM  = 4'd5;
    localparam logic [3:0] S_ADSCAN = 4'd6;
    localparam logic [3:0] S_ADCOM  = 4'd7;
    localparam logic [3:0] S_QRUN   = 4'd8;
    localparam logic [3:0] S_QDRAIN = 4'd9;
    localparam logic [3:0] S_DONE   = 4'd10;
    localparam logic [3:0] S_CLEAR  = 4'd11;

    logic [3:0]                state_reg, state_next;
    logic [rvfc_pkg::AW:0]     pos_reg, pos_next;
    logic [rvfc_pkg::SW:0]     slot_reg, slot_next;
    logic                      pend_reg, pend_next;
    logic                      pend_tab_reg, pend_tab_next;
    logic [rvfc_pkg::AW-1:0]   blk_base;
    logic [rvfc_pkg::AW:0]     rgt;

    assign blk_base = {sts.left[rvfc_pkg::AW-1:rvfc_pkg::SW], {rvfc_pkg::SW{1'b0}}};
    assign rgt      = {1'b0, sts.right};
    assign busy     = (state_reg != S_IDLE);

    always_comb
    begin
        cmd           = '0;
        state_next    = state_reg;
        pos_next      = pos_reg;
        slot_next     = slot_reg;
        pend_next     = 1'b0;
        pend_tab_next = 1'b0;
        done          = 1'b0;
        cmd.tab_addr  = blk_base | rvfc_pkg::AW'(slot_reg[rvfc_pkg::SW-1:0]);
        cmd.elem_addr = pos_reg[rvfc_pkg::AW-1:0];
        unique case (state_reg)
            S_CLEAR:
            begin
                // write one element and one table slot per cycle after reset
                cmd.clr      = 1'b1;
                cmd.elem_wr  = 1'b1;
                cmd.tab_wr   = 1'b1;
                cmd.tab_addr = pos_reg[rvfc_pkg::AW-1:0];
                pos_next     = pos_reg + 1'b1;
                if (pos_reg == (rvfc_pkg::AW+1)'(rvfc_pkg::DEPTH - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                pos_next  = {1'b0, sts.left};
                slot_next = '0;
                state_next = (sts.is_query == rvfc_pkg::KIND_QUERY) ? S_QRUN : S_OLD;
            end
            S_OLD:
            begin
                cmd.elem_addr = sts.left;
                cmd.elem_rd   = 1'b1;
                state_next    = S_OLDCAP;
            end
            S_OLDCAP:
            begin
                cmd.scan_clr = 1'b1;
                cmd.elem_wr  = 1'b1;
                state_next   = S_RMSCAN;
            end
            S_RMSCAN, S_ADSCAN:
            begin
                // read one slot per cycle, evaluate it the next
                if (pend_reg)
                begin
                    cmd.scan_rm  = (state_reg == S_RMSCAN);
                    cmd.scan_add = (state_reg == S_ADSCAN);
                end
                if (slot_reg != rvfc_pkg::BLOCK)
                begin
                    cmd.tab_rd = 1'b1;
                    pend_next  = 1'b1;
                    slot_next  = slot_reg + 1'b1;
                end
                else if (!pend_reg)
                    state_next = (state_reg == S_RMSCAN) ? S_RMCOM : S_ADCOM;
            end
            S_RMCOM:
            begin
                // drop the removal match before the insertion scan
                cmd.commit_rm = 1'b1;
                cmd.tab_wr    = 1'b1;
                cmd.scan_clr  = 1'b1;
                cmd.tab_addr  = blk_base;
                slot_next     = '0;
                state_next    = S_ADSCAN;
            end
            S_ADCOM:
            begin
                cmd.tab_wr     = 1'b1;
                state_next     = S_IDLE;
            end
            S_QRUN:
            begin
                cmd.acc_elem = pend_reg;
                cmd.acc_tab  = pend_tab_reg;
                if (pos_reg <= rgt)
                begin
                    if (pos_reg[rvfc_pkg::SW-1:0] == '0 &&
                        pos_reg + rvfc_pkg::AW'(rvfc_pkg::BLOCK - 1) <= rgt)
                    begin
                        // whole block: read each slot of its table for the value
                        cmd.tab_rd    = 1'b1;
                        cmd.tab_addr  = pos_reg[rvfc_pkg::AW-1:0]
                                      | rvfc_pkg::AW'(slot_reg[rvfc_pkg::SW-1:0]);
                        pend_tab_next = 1'b1;
                        if (slot_reg == rvfc_pkg::BLOCK - 1)
                        begin
                            slot_next = '0;
                            pos_next  = pos_reg + (rvfc_pkg::AW+1)'(rvfc_pkg::BLOCK);
                        end
                        else
                            slot_next = slot_reg + 1'b1;
                    end
                    else
                    begin
                        cmd.elem_rd = 1'b1;
                        pend_next   = 1'b1;
                        pos_next    = pos_reg + 1'b1;
                    end
                end
                else
                    state_next = S_QDRAIN;
            end
            S_QDRAIN:
            begin
                cmd.acc_elem = pend_reg;
                cmd.acc_tab  = pend_tab_reg;
                state_next   = S_DONE;
            end
            S_DONE:
            begin
                done       = 1'b1;
                state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            pos_reg      <= '0;
            slot_reg     <= '0;
            pend_reg     <= 1'b0;
            pend_tab_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            pos_reg      <= pos_next;
            slot_reg     <= slot_next;
            pend_reg     <= pend_next;
            pend_tab_reg <= pend_tab_next;
        end
    end

endmodule

// ===== sv/range_value_frequency_counter.sv =====
// ----------------------------------------------------------------------------
// range_value_frequency_counter: count a value's occurrences in an index range
// Element store split in blocks of 16 with per-block (value, count) tables.
// ----------------------------------------------------------------------------
// Usage: drive kind, left_index, right_index, item_value and raise start
// while busy is low; the item is taken at that edge. A write (kind 0) sets
// one element and updates its block table; it gives no result and holds
// busy through the table scans for removal and insertion, one slot per
// cycle each. A query (kind 1) walks partial blocks one element a cycle
// and whole blocks one table slot a cycle, with busy held throughout.
// match_count is valid for exactly one cycle while done is high, in the
// last busy cycle; the receiver cannot stall.
// Reset clears all control state; then a clearing pass, with busy high,
// zeroes the element store and loads each table with value 0 at count 16
// in its first slot. No item is taken during that pass.
// ----------------------------------------------------------------------------
module range_value_frequency_counter
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    output logic        done,
    input  logic        kind,
    input  logic [7:0]  left_index,
    input  logic [7:0]  right_index,
    input  logic [31:0] item_value,
    output logic [8:0]  match_count
);

    rvfc_pkg::rvfc_cmd_t cmd;
    rvfc_pkg::rvfc_sts_t sts;

    rvfc_controller u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .sts   (sts),
        .cmd   (cmd)
    );

    rvfc_datapath u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .kind        (kind),
        .left_index  (left_index),
        .right_index (right_index),
        .item_value  (item_value),
        .cmd         (cmd),
        .sts         (sts),
        .match_count (match_count)
    );

    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("done without busy");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done longer than one cycle");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("item taken but not busy");

endmodule

// ===== verif/range_value_frequency_counter_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// range_value_frequency_counter_checker: count predictor and result compare
// Watches accepted items, keeps its own element store and block tables,
// queues the expected match counts and checks each done strobe against them.
// ----------------------------------------------------------------------------
module range_value_frequency_counter_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic        done,
    input  logic        kind,
    input  logic [7:0]  left_index,
    input  logic [7:0]  right_index,
    input  logic [31:0] item_value,
    input  logic [8:0]  match_count,
    output int          error_count,
    output int          pending_counts
);

    logic [31:0]             elem_model [rvfc_pkg::DEPTH];
    logic [31:0]             slot_value [rvfc_pkg::DEPTH];
    logic [rvfc_pkg::CW-1:0] slot_count [rvfc_pkg::DEPTH];
    logic [8:0]              expected_counts [$];

    assign pending_counts = expected_counts.size();

    task automatic report_mismatch(input string msg);
        $display("ERROR %0t: %s", $realtime, msg);
        error_count++;
    endtask

    function automatic logic [rvfc_pkg::CW-1:0] lookup_block(input int blk,
                                                             input logic [31:0] v);
        for (int s = 0; s < rvfc_pkg::BLOCK; s++)
            if (slot_count[blk*rvfc_pkg::BLOCK+s] != 0 &&
                slot_value[blk*rvfc_pkg::BLOCK+s] == v)
                return slot_count[blk*rvfc_pkg::BLOCK+s];
        return '0;
    endfunction

    task automatic apply_write(input int idx, input logic [31:0] v);
        int blk;
        bit placed;
        blk = idx / rvfc_pkg::BLOCK;
        for (int s = 0; s < rvfc_pkg::BLOCK; s++)
            if (slot_count[blk*rvfc_pkg::BLOCK+s] != 0 &&
                slot_value[blk*rvfc_pkg::BLOCK+s] == elem_model[idx])
            begin
                slot_count[blk*rvfc_pkg::BLOCK+s]--;
                break;
            end
        elem_model[idx] = v;
        placed = 0;
        for (int s = 0; s < rvfc_pkg::BLOCK && !placed; s++)
            if (slot_count[blk*rvfc_pkg::BLOCK+s] != 0 &&
                slot_value[blk*rvfc_pkg::BLOCK+s] == v)
            begin
                slot_count[blk*rvfc_pkg::BLOCK+s]++;
                placed = 1;
            end
        for (int s = 0; s < rvfc_pkg::BLOCK && !placed; s++)
            if (slot_count[blk*rvfc_pkg::BLOCK+s] == 0)
            begin
                slot_value[blk*rvfc_pkg::BLOCK+s] = v;
                slot_count[blk*rvfc_pkg::BLOCK+s] = 1;
                placed = 1;
            end
    endtask

    function automatic logic [8:0] count_in_range(input int lo, input int hi,
                                                  input logic [31:0] v);
        int cnt;
        int l;
        cnt = 0;
        l = lo;
        if (hi > rvfc_pkg::DEPTH - 1)
            hi = rvfc_pkg::DEPTH - 1;
        while (l <= hi && (l % rvfc_pkg::BLOCK) != 0)
        begin
            if (elem_model[l] == v) cnt++;
            l++;
        end
        while (l + rvfc_pkg::BLOCK - 1 <= hi)
        begin
            cnt += lookup_block(l / rvfc_pkg::BLOCK, v);
            l += rvfc_pkg::BLOCK;
        end
        while (l <= hi)
        begin
            if (elem_model[l] == v) cnt++;
            l++;
        end
        return cnt[8:0];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            error_count = 0;
            expected_counts.delete();
            for (int i = 0; i < rvfc_pkg::DEPTH; i++)
            begin
                elem_model[i] = '0;
                slot_value[i] = '0;
                slot_count[i] = (i % rvfc_pkg::BLOCK == 0)
                              ? rvfc_pkg::CW'(rvfc_pkg::BLOCK) : '0;
            end
        end
        else
        begin
            // check first: a result never belongs to an item taken at the same edge
            if (done)
            begin
                if (expected_counts.size() == 0)
                    report_mismatch($sformatf("unexpected result %0d", match_count));
                else
                begin
                    logic [8:0] exp_cnt;
                    exp_cnt = expected_counts.pop_front();
                    if (match_count !== exp_cnt)
                        report_mismatch($sformatf("match_count %0d, expected %0d",
                                                  match_count, exp_cnt));
                end
            end
            if (start && !busy)
            begin
                if (kind == rvfc_pkg::KIND_WRITE)
                    apply_write(left_index, item_value);
                else
                    expected_counts.insert(expected_counts.size(),
                                           count_in_range(left_index, right_index,
                                                          item_value));
            end
        end
    end

endmodule

// ===== verif/range_value_frequency_counter_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// range_value_frequency_counter_test: top of the counter testbench
// Directed edge items, then random writes and queries over a small value
// pool under several sender idling phases; verdict from the checker.
// ----------------------------------------------------------------------------
module range_value_frequency_counter_test;

    localparam int WATCHDOG_LIMIT = 5000;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        done;
    logic        kind;
    logic [7:0]  left_index;
    logic [7:0]  right_index;
    logic [31:0] item_value;
    logic [8:0]  match_count;
    int          error_count;
    int          pending_counts;
    int          idle_pct;
    int          quiet_cycles;
    logic [31:0] value_pool [8];

    range_value_frequency_counter i_dut (.*);

    range_value_frequency_counter_checker i_checker (.*);

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // give up when nothing is taken or returned for too long
    always @(posedge clk)
    begin
        if ((start && !busy) || done || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // start stays high after the item is taken; the next item or an idle
    // cycle replaces it, and busy keeps the stale one from being taken
    task automatic send_item(input logic k, input logic [7:0] l, input logic [7:0] r,
                             input logic [31:0] v);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start       <= 1'b1;
        kind        <= k;
        left_index  <= l;
        right_index <= r;
        item_value  <= v;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    function automatic logic [31:0] pick_value();
        if ($urandom_range(9) == 0)
            return $urandom();
        return value_pool[$urandom_range(7)];
    endfunction

    task automatic random_item();
        logic [7:0] l;
        logic [7:0] r;
        l = 8'($urandom());
        r = 8'($urandom());
        if ($urandom_range(3) != 0 && l > r)
            {l, r} = {r, l};
        // keep most ranges short so the run stays fast
        if ($urandom_range(3) != 0 && r > l + 20)
            r = l + 8'($urandom_range(20));
        send_item($urandom_range(1) ? rvfc_pkg::KIND_QUERY : rvfc_pkg::KIND_WRITE,
                  l, r, pick_value());
    endtask

    initial
    begin
        rst_n       = 1'b0;
        start       = 1'b0;
        kind        = rvfc_pkg::KIND_WRITE;
        left_index  = '0;
        right_index = '0;
        item_value  = '0;
        idle_pct    = 0;
        value_pool  = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                        32'h5A5A_A5A5, 32'hA5A5_5A5A, 32'h0000_0003};
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // fresh store: zeros everywhere
        send_item(rvfc_pkg::KIND_QUERY, 8'd0, 8'd255, 32'h0);
        send_item(rvfc_pkg::KIND_QUERY, 8'd3, 8'd200, 32'h0);
        send_item(rvfc_pkg::KIND_QUERY, 8'd9, 8'd8, 32'h0);
        send_item(rvfc_pkg::KIND_WRITE, 8'd0, 8'd255, 32'h8000_0000);
        send_item(rvfc_pkg::KIND_WRITE, 8'd255, 8'd0, 32'h7FFF_FFFF);
        send_item(rvfc_pkg::KIND_WRITE, 8'd15, 8'd0, 32'hFFFF_FFFF);
        send_item(rvfc_pkg::KIND_WRITE, 8'd16, 8'd0, 32'hFFFF_FFFF);
        send_item(rvfc_pkg::KIND_WRITE, 8'd17, 8'd0, 32'hFFFF_FFFF);
        send_item(rvfc_pkg::KIND_WRITE, 8'd17, 8'd0, 32'h0);
        send_item(rvfc_pkg::KIND_QUERY, 8'd0, 8'd255, 32'hFFFF_FFFF);
        send_item(rvfc_pkg::KIND_QUERY, 8'd15, 8'd16, 32'hFFFF_FFFF);
        send_item(rvfc_pkg::KIND_QUERY, 8'd0, 8'd0, 32'h8000_0000);
        send_item(rvfc_pkg::KIND_QUERY, 8'd255, 8'd255, 32'h7FFF_FFFF);
        send_item(rvfc_pkg::KIND_QUERY, 8'd255, 8'd0, 32'h7FFF_FFFF);
        send_item(rvfc_pkg::KIND_QUERY, 8'd16, 8'd31, 32'h0);
        send_item(rvfc_pkg::KIND_QUERY, 8'd1, 8'd254, 32'h0);
        // fill one block with distinct values so its table is full
        for (int i = 32; i < 48; i++)
            send_item(rvfc_pkg::KIND_WRITE, 8'(i), 8'd0, 32'h1000 + i);
        send_item(rvfc_pkg::KIND_QUERY, 8'd32, 8'd47, 32'h1000 + 40);
        start <= 1'b0;

        // hold off until every count is back
        while (pending_counts != 0)
            @(posedge clk);

        for (int ph = 0; ph < 4; ph++)
        begin
            idle_pct = (ph == 1) ? 48 : (ph == 3) ? 18 : 0;
            repeat (480) random_item();
        end
        start <= 1'b0;

        while (pending_counts != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
